FILE: rtl/scfl_pkg.sv
// Package for the size-class free-list allocator: widths, codes, state type,
// link memory command struct and the size-to-class function.
// Depends on nothing; every other file imports it.
package scfl_pkg;

   localparam int NUM_BLOCKS  = 1024;
   localparam int NUM_CLASSES = 15;
   localparam int MAX_SIZE    = 65536;

   localparam int MIN_BYTES      = 4;
   localparam int TOP_CLASS      = 14;
   localparam int BLOCK_W        = $clog2(NUM_BLOCKS);
   localparam int LINK_W         = BLOCK_W + 1;
   localparam int SIZE_W         = 17;
   localparam int CLASS_W        = 4;
   localparam int ID_W           = 10;
   localparam int CLASS_IDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   // A link or head with its top bit set marks the end of a list.
   localparam logic [LINK_W-1:0] LINK_EMPTY = {1'b1, {BLOCK_W{1'b0}}};

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } scfl_op_type;

   typedef enum logic [1:0] {
      ST_GRANT   = 2'd0,
      ST_MISS    = 2'd1,
      ST_INVALID = 2'd2,
      ST_FREED   = 2'd3
   } scfl_status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_WORK = 1'b1
   } scfl_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [BLOCK_W-1:0] rd_addr;
      logic              wr_en;
      logic [BLOCK_W-1:0] wr_addr;
      logic [LINK_W-1:0]  wr_data;
   } scfl_link_cmd_type;

   // Smallest class k with (4 << k) >= size; each compare is independent.
   function automatic logic [CLASS_W-1:0] size_class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] k;
      k = '0;
      for (int j = 1; j <= TOP_CLASS; j++) begin
         if (size > (SIZE_W'(MIN_BYTES) << (j - 1))) begin
            k = CLASS_W'(j);
         end
      end
      return k;
   endfunction

endpackage

FILE: rtl/scfl_if.sv
// Handshake interfaces for the request and response channels of the allocator.
// Depends on scfl_pkg for field widths and the status type.
interface scfl_req_if import scfl_pkg::*; ();
   logic               valid;
   logic               ready;
   scfl_op_type        req_type;
   logic [SIZE_W-1:0]  request_size;
   logic [ID_W-1:0]    block_id;

   modport source (output valid, output req_type, output request_size, output block_id,
                   input ready);
   modport sink   (input valid, input req_type, input request_size, input block_id,
                   output ready);
endinterface

interface scfl_rsp_if import scfl_pkg::*; ();
   logic               valid;
   logic               ready;
   scfl_status_type    status;
   logic [ID_W-1:0]    granted_block;
   logic [CLASS_W-1:0] size_class;
   logic [SIZE_W-1:0]  class_bytes;

   modport source (output valid, output status, output granted_block, output size_class,
                   output class_bytes, input ready);
   modport sink   (input valid, input status, input granted_block, input size_class,
                   input class_bytes, output ready);
endinterface

FILE: rtl/size_class_free_list_allocator.sv
// Top level of the size-class free-list allocator: head registers, sequencer
// and response register. Depends on scfl_pkg, scfl_if.sv and scfl_link_ram.
//
//   channel    | direction | carries
//   -----------+-----------+-----------------------------------------------
//   req_chan   | in        | req_type, request_size, block_id
//   rsp_chan   | out       | status, granted_block, size_class, class_bytes
//
// Each request is accepted in the idle state, which selects the class head and
// reads the link memory at it; the work state then writes the link memory on a
// push, updates the head and loads the response register. The registered read
// of the link memory is why the work state exists, since a pop needs the link
// before the head can move. A new transaction may be accepted while a response
// still waits; the work state then holds until the response register drains.
// Reset is synchronous and empties every class list; the link memory is not
// cleared, since a link is always written before it can be read.
module size_class_free_list_allocator import scfl_pkg::*; (
   input  logic clock,
   input  logic reset,
   scfl_req_if.sink   req_chan,
   scfl_rsp_if.source rsp_chan
);

   // Sequencer state.
   scfl_state_type state_ff, state_in;

   // One head per class; the top bit marks an empty list.
   logic [LINK_W-1:0] heads_ff [NUM_CLASSES];

   // Request captured at accept.
   logic               ok_ff;
   scfl_op_type        op_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic [BLOCK_W-1:0] bid_ff;
   logic [LINK_W-1:0]  head_ff;

   // Response register.
   logic               rsp_valid_ff;
   scfl_status_type    status_ff;
   logic [ID_W-1:0]    granted_ff;
   logic [CLASS_W-1:0] rsp_cls_ff;
   logic [SIZE_W-1:0]  bytes_ff;

   logic               accept;
   logic               commit;
   logic [CLASS_W-1:0] acc_cls;
   logic               acc_ok;
   logic [LINK_W-1:0]  acc_head;
   logic [LINK_W-1:0]  link_rd;
   scfl_link_cmd_type  link_cmd;

   // Decode of the incoming transaction. A size is valid from 1 to MAX_SIZE,
   // its class must exist, and a freed block number must be in range.
   always_comb begin
      acc_cls = size_class_of(req_chan.request_size);
      acc_ok  = (req_chan.request_size != '0)
             && ({1'b0, req_chan.request_size} <= (SIZE_W + 1)'(MAX_SIZE))
             && ({1'b0, acc_cls} < (CLASS_W + 1)'(NUM_CLASSES))
             && !((req_chan.req_type == OP_FREE)
                  && ({1'b0, req_chan.block_id} < (ID_W + 1)'(NUM_BLOCKS)) == 1'b0);
      acc_head = LINK_EMPTY;
      if (acc_ok) begin
         acc_head = heads_ff[acc_cls[CLASS_IDX_W-1:0]];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_chan.valid) state_in = FSM_WORK;
         end
         FSM_WORK: begin
            if (commit) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Handshake and commit strobes.
   always_comb begin
      req_chan.ready = (state_ff == FSM_IDLE);
      commit         = (state_ff == FSM_WORK) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign accept = req_chan.valid && req_chan.ready;

   // The link memory is read in the accept cycle at the current head and
   // written in the commit cycle when a block is pushed; the two never meet.
   always_comb begin
      link_cmd.rd_en   = accept;
      link_cmd.rd_addr = acc_head[BLOCK_W-1:0];
      link_cmd.wr_en   = commit && ok_ff && (op_ff == OP_FREE);
      link_cmd.wr_addr = bid_ff;
      link_cmd.wr_data = head_ff;
   end

   scfl_link_ram u_link_ram (
      .clock   (clock),
      .cmd     (link_cmd),
      .rd_data (link_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff   <= acc_ok;
         op_ff   <= req_chan.req_type;
         cls_ff  <= acc_cls;
         bid_ff  <= req_chan.block_id[BLOCK_W-1:0];
         head_ff <= acc_head;
      end
   end

   // Head update: a push makes the freed block the head, a pop moves the head
   // to the link read in the accept cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= LINK_EMPTY;
         end
      end else if (commit && ok_ff) begin
         if (op_ff == OP_FREE) begin
            heads_ff[cls_ff[CLASS_IDX_W-1:0]] <= {1'b0, bid_ff};
         end else if (!head_ff[LINK_W-1]) begin
            heads_ff[cls_ff[CLASS_IDX_W-1:0]] <= link_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         granted_ff <= '0;
         if (!ok_ff) begin
            status_ff  <= ST_INVALID;
            rsp_cls_ff <= '0;
            bytes_ff   <= '0;
         end else begin
            rsp_cls_ff <= cls_ff;
            bytes_ff   <= SIZE_W'(MIN_BYTES) << cls_ff;
            priority if (op_ff == OP_FREE) begin
               status_ff <= ST_FREED;
            end else if (head_ff[LINK_W-1]) begin
               status_ff <= ST_MISS;
            end else begin
               status_ff  <= ST_GRANT;
               granted_ff <= ID_W'(head_ff[BLOCK_W-1:0]);
            end
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.granted_block = granted_ff;
   assign rsp_chan.size_class    = rsp_cls_ff;
   assign rsp_chan.class_bytes   = bytes_ff;

   // An accepted transaction always moves the sequencer into its work cycle.
   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == FSM_WORK))
      else $error("accepted transaction did not enter the work cycle");

   // The link memory is never read and written in the same cycle.
   a_link_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(link_cmd.rd_en && link_cmd.wr_en))
      else $error("link memory read and write collide");

   // A grant always names a real class size.
   a_grant_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_GRANT)) |-> (bytes_ff != '0))
      else $error("grant with zero class size");

   // A rejected request reports neither a block nor a class.
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_INVALID))
         |-> ((granted_ff == '0) && (rsp_cls_ff == '0) && (bytes_ff == '0)))
      else $error("invalid response carries data");

   // A response is loaded only by the commit of a work cycle.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit))
      else $error("response appeared without a commit");

endmodule

FILE: rtl/scfl_link_ram.sv
// Next-link memory of the free lists, one entry per block, registered read.
// Depends on scfl_pkg for the command struct and widths.
module scfl_link_ram import scfl_pkg::*; (
   input  logic              clock,
   input  scfl_link_cmd_type cmd,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] mem [NUM_BLOCKS];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_size_class_free_list_allocator.sv
// Testbench for size_class_free_list_allocator: a self-checking run that models
// every class free list and checks each response field by field.
// Depends on scfl_pkg, scfl_if.sv and the allocator RTL.
`timescale 1ns / 1ps

module tb_size_class_free_list_allocator;
   import scfl_pkg::*;

   // Pacing of the two channels. Each request carries the pace it was
   // generated under, so the stall pattern follows the traffic.
   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH_IDLE
   } pace_type;

   typedef struct packed {
      scfl_op_type        op;
      logic [SIZE_W-1:0]  size;
      logic [ID_W-1:0]    blk;
      pace_type           pace;
   } alloc_req_type;

   typedef struct packed {
      scfl_status_type    status;
      logic [ID_W-1:0]    granted;
      logic [CLASS_W-1:0] cls;
      logic [SIZE_W-1:0]  bytes;
   } alloc_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [CLASS_W-1:0] cls;
   } held_block_type;

   // Two copies of the free-list state: one walks ahead while the stimulus is
   // built (so the generator knows which blocks it owns), the other follows
   // the transactions the block actually accepts and supplies expectations.
   localparam int GEN_VIEW  = 0;
   localparam int CHK_VIEW  = 1;

   localparam int RANDOM_ITEMS = 1450;
   localparam int PACE_SPAN    = 120;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   logic clock;
   logic reset;

   scfl_req_if req_chan ();
   scfl_rsp_if rsp_chan ();

   size_class_free_list_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [LINK_W-1:0] list_heads [2][NUM_CLASSES];
   logic [LINK_W-1:0] list_links [2][NUM_BLOCKS];

   alloc_req_type  pending_reqs [$];
   alloc_rsp_type  expected_rsps [$];
   held_block_type held_blocks [$];

   alloc_req_type in_flight;
   pace_type      live_pace;
   pace_type      build_pace;
   int unsigned   error_count;
   int unsigned   rsp_count;
   int unsigned   cycle_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicts one request against the chosen copy of the lists and applies
   // its effect: allocations pop the class head, frees push onto it.
   function automatic alloc_rsp_type predict_alloc(input int view, input alloc_req_type r);
      alloc_rsp_type      o;
      logic [CLASS_W-1:0] k;
      logic [LINK_W-1:0]  h;
      o.status  = ST_INVALID;
      o.granted = '0;
      o.cls     = '0;
      o.bytes   = '0;
      if (r.size == '0 || r.size > MAX_SIZE) begin
         return o;
      end
      // Round up to the smallest power-of-two class that holds the size.
      k = '0;
      while (k < TOP_CLASS && (MIN_BYTES << k) < r.size) begin
         k++;
      end
      if (k >= NUM_CLASSES || (r.op == OP_FREE && r.blk >= NUM_BLOCKS)) begin
         return o;
      end
      o.cls   = k;
      o.bytes = SIZE_W'(MIN_BYTES << k);
      if (r.op == OP_FREE) begin
         // A double free is not caught; the block is simply pushed again.
         list_links[view][r.blk] = list_heads[view][k];
         list_heads[view][k]     = {1'b0, r.blk};
         o.status = ST_FREED;
      end else if (list_heads[view][k][LINK_W-1]) begin
         o.status = ST_MISS;
      end else begin
         h = list_heads[view][k];
         o.granted = h[BLOCK_W-1:0];
         list_heads[view][k] = list_links[view][h[BLOCK_W-1:0]];
         o.status = ST_GRANT;
      end
      return o;
   endfunction

   // Random size that falls exactly in class k: just above the class below,
   // up to the class chunk size. Class 0 covers 1 to 4 bytes.
   function automatic logic [SIZE_W-1:0] size_in_class(input int unsigned k);
      int unsigned lo;
      int unsigned hi;
      hi = MIN_BYTES << k;
      lo = (k == 0) ? 1 : (MIN_BYTES << (k - 1)) + 1;
      return SIZE_W'($urandom_range(hi, lo));
   endfunction

   // Most traffic sits in a few small classes so lists get deep and reused;
   // the rest spreads over every class up to 64 KiB.
   function automatic int unsigned pick_class();
      if ($urandom_range(99, 0) < 60) begin
         return $urandom_range(2, 0);
      end
      return $urandom_range(TOP_CLASS, 0);
   endfunction

   // Queues one request and tracks which blocks the generator now owns.
   task automatic queue_item(input scfl_op_type op, input int unsigned size,
                             input int unsigned blk);
      alloc_req_type  r;
      alloc_rsp_type  o;
      held_block_type hb;
      r.op   = op;
      r.size = SIZE_W'(size);
      r.blk  = ID_W'(blk);
      r.pace = build_pace;
      o = predict_alloc(GEN_VIEW, r);
      if (o.status == ST_GRANT) begin
         hb.id  = o.granted;
         hb.cls = o.cls;
         held_blocks.push_back(hb);
      end
      pending_reqs.push_back(r);
   endtask

   task automatic queue_random_item();
      int unsigned roll;
      int unsigned pick;
      held_block_type hb;
      roll = $urandom_range(99, 0);
      if (roll < 5) begin
         // Zero or oversized request, either operation.
         queue_item(scfl_op_type'($urandom_range(1, 0)),
                    ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(131071, MAX_SIZE + 1),
                    $urandom_range(NUM_BLOCKS - 1, 0));
      end else if (roll < 20) begin
         // Stray free of any block: seeds lists, and sometimes frees twice.
         queue_item(OP_FREE, size_in_class(pick_class()), $urandom_range(NUM_BLOCKS - 1, 0));
      end else if (roll < 60 && held_blocks.size() > 0) begin
         // Well-formed return of a block this run was granted earlier.
         pick = $urandom_range(held_blocks.size() - 1, 0);
         hb = held_blocks[pick];
         held_blocks.delete(pick);
         queue_item(OP_FREE, size_in_class(hb.cls), hb.id);
      end else begin
         queue_item(OP_ALLOC, size_in_class(pick_class()), $urandom_range(NUM_BLOCKS - 1, 0));
      end
   endtask

   function automatic bit sender_idles(input pace_type p);
      if (p == PACE_SENDER_IDLE) begin
         return $urandom_range(99, 0) < 70;
      end
      if (p == PACE_BOTH_IDLE) begin
         return $urandom_range(99, 0) < 25;
      end
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls(input pace_type p);
      if (p == PACE_RECEIVER_STALL) begin
         return $urandom_range(99, 0) < 70;
      end
      if (p == PACE_BOTH_IDLE) begin
         return $urandom_range(99, 0) < 25;
      end
      return 1'b0;
   endfunction

   task automatic flag_error(input string msg);
      if (error_count < MAX_REPORTS) begin
         $display("%s", msg);
      end
      error_count++;
   endtask

   // Request driver. A transaction completes at an edge where valid and ready
   // were both high; its expectation is computed right there, in accept
   // order, and the next request (if any and not idling) goes out at once.
   // valid is assigned once per edge, so back-to-back requests never glitch.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.req_type     <= OP_ALLOC;
         req_chan.request_size <= '0;
         req_chan.block_id     <= '0;
         live_pace             <= PACE_STEADY;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back(predict_alloc(CHK_VIEW, in_flight));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 && !sender_idles(pending_reqs[0].pace)) begin
               in_flight = pending_reqs.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.req_type     <= in_flight.op;
               req_chan.request_size <= in_flight.size;
               req_chan.block_id     <= in_flight.blk;
               live_pace             <= in_flight.pace;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every completed response transaction is matched with
   // the oldest expectation; ready is redrawn each cycle from the live pace.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               flag_error($sformatf("response %0d arrived with nothing expected", rsp_count));
            end else begin
               alloc_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_chan.status !== e.status || rsp_chan.granted_block !== e.granted ||
                   rsp_chan.size_class !== e.cls || rsp_chan.class_bytes !== e.bytes) begin
                  flag_error($sformatf({"response %0d: expected status %0d block %0d ",
                     "class %0d bytes %0d, got status %0d block %0d class %0d bytes %0d"},
                     rsp_count, e.status, e.granted, e.cls, e.bytes, rsp_chan.status,
                     rsp_chan.granted_block, rsp_chan.size_class, rsp_chan.class_bytes));
               end
            end
            rsp_count++;
         end
         rsp_chan.ready <= !receiver_stalls(live_pace);
      end
   end

   // Watchdog: far above the slowest legal run of this stimulus.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      error_count = 0;
      rsp_count   = 0;
      cycle_count = 0;
      build_pace  = PACE_STEADY;
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            list_heads[v][c] = LINK_EMPTY;
         end
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            list_links[v][b] = '0;
         end
      end

      // Directed opening: rejected sizes, the 1-to-3 byte sizes, both ends of
      // the block numbers, the 64 KiB class, misses, and a double free that
      // leaves a class list pointing at itself.
      queue_item(OP_ALLOC, 0, 0);
      queue_item(OP_FREE, 131071, NUM_BLOCKS - 1);
      queue_item(OP_ALLOC, MAX_SIZE + 1, 0);
      queue_item(OP_FREE, 0, 7);
      queue_item(OP_ALLOC, 1, 0);
      queue_item(OP_FREE, 3, 0);
      queue_item(OP_FREE, 2, NUM_BLOCKS - 1);
      queue_item(OP_ALLOC, 4, 0);
      queue_item(OP_ALLOC, 1, NUM_BLOCKS - 1);
      queue_item(OP_ALLOC, 2, 0);
      queue_item(OP_FREE, MAX_SIZE, 512);
      queue_item(OP_ALLOC, MAX_SIZE, 0);
      queue_item(OP_ALLOC, 32769, 0);
      queue_item(OP_FREE, 5, 341);
      queue_item(OP_FREE, 8, 682);
      queue_item(OP_ALLOC, 6, 0);
      queue_item(OP_FREE, 7, 341);
      queue_item(OP_ALLOC, 8, 0);
      queue_item(OP_ALLOC, 5, 0);
      queue_item(OP_FREE, 4096, 100);
      queue_item(OP_ALLOC, 2049, 0);
      queue_item(OP_ALLOC, 4097, 0);

      // Random part, rotating through the pacing modes in fixed stretches.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         build_pace = pace_type'((i / PACE_SPAN) % 4);
         queue_random_item();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_chan.valid) begin
         @(posedge clock);
      end
      while (expected_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rsps.size() > 0) begin
         flag_error("responses still outstanding at end of run");
      end
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/scfl_pkg.sv
rtl/scfl_if.sv
rtl/scfl_link_ram.sv
rtl/size_class_free_list_allocator.sv
test/tb_size_class_free_list_allocator.sv
